FILE: design/nscc_pkg.sv
// Shared types, widths and the hex digit decoder for the NMEA checksum checker.
package nscc_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned NIBBLE_W    = 4;
    localparam int unsigned COUNT_W     = 3;
    localparam int unsigned TAIL_DEPTH  = 3;
    localparam int unsigned OUT_TDATA_W = 24;

    // Count at which the delay line is full and its oldest byte belongs to the sum
    localparam logic [COUNT_W-1:0] COUNT_FULL  = 3'd4;
    // Fewest earlier bytes for a sentence that carries a checksum
    localparam logic [COUNT_W-1:0] COUNT_MIN   = 3'd2;

    localparam logic [BYTE_W-1:0] CH_0       = 8'h30;  // '0'
    localparam logic [BYTE_W-1:0] CH_9       = 8'h39;  // '9'
    localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;  // 'A'
    localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;  // 'Z'
    localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;  // 'a'
    localparam logic [BYTE_W-1:0] CH_LOWER_F = 8'h66;  // 'f'
    localparam logic [BYTE_W-1:0] CASE_GAP   = 8'h20;  // 'a' - 'A'
    localparam logic [BYTE_W-1:0] HEX_TEN    = 8'd10;

    // One checked sentence
    typedef struct packed {
        logic              too_short;
        logic [BYTE_W-1:0] received_sum;
        logic [BYTE_W-1:0] computed_sum;
        logic              sums_match;
    } t_result;

    // Decode one checksum character; anything that is not a hex digit reads as zero
    function automatic logic [NIBBLE_W-1:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] lc;
        logic [BYTE_W-1:0] v;
        lc = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            lc = c + CASE_GAP;
        end
        v = '0;
        if (lc >= CH_0 && lc <= CH_9) begin
            v = lc - CH_0;
        end else if (lc >= CH_LOWER_A && lc <= CH_LOWER_F) begin
            v = lc - CH_LOWER_A + HEX_TEN;
        end
        return v[NIBBLE_W-1:0];
    endfunction

endpackage

FILE: design/nscc_xor_core.sv
// Running XOR, three-byte tail delay and checksum compare for one sentence byte.
module nscc_xor_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic [nscc_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_last,
    output nscc_pkg::t_result          o_result
);

    logic [nscc_pkg::BYTE_W-1:0]  r_xor;
    logic [nscc_pkg::BYTE_W-1:0]  r_tail [nscc_pkg::TAIL_DEPTH];
    logic [nscc_pkg::COUNT_W-1:0] r_count;

    logic [nscc_pkg::BYTE_W-1:0]  n_xor;
    logic                         w_short;

    // Fold in the byte leaving the delay once the line is full
    assign n_xor   = (r_count >= nscc_pkg::COUNT_FULL) ? (r_xor ^ r_tail[2]) : r_xor;
    assign w_short = (r_count < nscc_pkg::COUNT_MIN);

    // Build the result for a final byte
    always_comb begin
        o_result.too_short    = w_short;
        o_result.computed_sum = w_short ? '0 : n_xor;
        o_result.received_sum = w_short ? '0 :
                                {nscc_pkg::hex_digit(r_tail[0]), nscc_pkg::hex_digit(i_byte)};
        o_result.sums_match   = !w_short && (n_xor == {nscc_pkg::hex_digit(r_tail[0]),
                                                       nscc_pkg::hex_digit(i_byte)});
    end

    // Advance the sentence state; clear it after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor   <= '0;
            r_tail  <= '{default: '0};
            r_count <= '0;
        end else if (i_fire) begin
            if (i_last) begin
                r_xor   <= '0;
                r_tail  <= '{default: '0};
                r_count <= '0;
            end else begin
                r_xor     <= n_xor;
                r_tail[2] <= r_tail[1];
                r_tail[1] <= r_tail[0];
                r_tail[0] <= i_byte;
                if (r_count < nscc_pkg::COUNT_FULL) begin
                    r_count <= r_count + 3'd1;
                end
            end
        end
    end

endmodule

FILE: design/nscc_out_stage.sv
// Result register that holds one checked sentence until the sink takes it.
module nscc_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  nscc_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output nscc_pkg::t_result o_result
);

    logic              r_valid;
    nscc_pkg::t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Hold the result until taken; load a new one when the slot frees
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && o_free) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: design/nmea_sentence_checksum_check_core.sv
// Top level of the NMEA 0183 sentence checksum checker.
//
//  channel  | dir | tdata                              | tlast / tuser
//  ---------+-----+------------------------------------+-------------------------
//  s (in)   | in  | [7:0] char_byte                    | tlast = end_of_sentence
//  m (out)  | out | [0] sums_match, [8:1] computed_sum,| tuser = too_short
//           |     | [16:9] received_sum, [23:17] zero  |
//
// One byte is taken every cycle unless a final byte waits for the result slot; a
// byte passes the input register, then the XOR/compare logic, and a final byte's
// result lands in the result register. Only final bytes produce a word.
// Reset is synchronous, active low, and clears the sentence state.
// A stalled result blocks only a final byte waiting behind it.
module nmea_sentence_checksum_check_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_byte
    input  logic        i_s_tlast,   // end_of_sentence
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [0] sums_match, [8:1] computed_sum, [16:9] received_sum
    output logic        o_m_tuser    // [0] too_short
);

    logic                        r_in_valid;
    logic [nscc_pkg::BYTE_W-1:0] r_in_byte;
    logic                        r_in_last;

    logic              w_out_free;
    logic              w_fire;
    nscc_pkg::t_result w_result;
    nscc_pkg::t_result w_out_result;

    // Advance the input register unless its final word waits for the result slot
    assign w_fire     = r_in_valid && (!r_in_last || w_out_free);
    assign o_s_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    nscc_xor_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (w_result)
    );

    nscc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire && r_in_last),
        .i_result (w_result),
        .i_ready  (i_m_tready),
        .o_free   (w_out_free),
        .o_valid  (o_m_tvalid),
        .o_result (w_out_result)
    );

    // Pack the result word
    assign o_m_tdata = {7'd0, w_out_result.received_sum, w_out_result.computed_sum,
                        w_out_result.sums_match};
    assign o_m_tuser = w_out_result.too_short;

endmodule

FILE: design/nscc_checker.sv
// Port-level checks on the checksum checker's result stream, bound to the top level.
module nscc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tuser
);

    // A stalled word stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result word dropped while stalled");

    // A short sentence reports no sums and no match
    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[16:0] == 17'd0)
        else $error("short sentence carries sums");

    // Match flag agrees with the two sums
    a_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[0] == (o_m_tdata[8:1] == o_m_tdata[16:9]))
        else $error("match flag disagrees with sums");

    // Padding bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[23:17] == 7'd0)
        else $error("padding bits set");

endmodule

bind nmea_sentence_checksum_check_core nscc_checker u_nscc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
